// File: rtl/apt_pkg.sv
`default_nettype none

package apt_pkg;

    // Integer bits of a linear coefficient; the rest are fraction bits.
    localparam int COEF_INT_BITS = 4;
    localparam int NUM_ROWS      = 3;

    typedef enum logic [2:0] {
        REG_ROW0_LINEAR = 3'd0,
        REG_ROW1_LINEAR = 3'd1,
        REG_ROW2_LINEAR = 3'd2,
        REG_SHIFT_X     = 3'd3,
        REG_SHIFT_Y     = 3'd4,
        REG_SHIFT_Z     = 3'd5
    } t_cfg_idx;

    // Load enables of the three lane pipeline stages.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_stage_en;

endpackage

`default_nettype wire

// File: rtl/apt_lane.sv
`default_nettype none

module apt_lane
    import apt_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int COEF_WIDTH  = 16
) (
    input  wire logic                          i_clk,
    input  wire t_stage_en                     i_en,
    input  wire logic [3*COEF_WIDTH-1:0]       i_coefs,
    input  wire logic signed [COORD_WIDTH-1:0] i_shift,
    input  wire logic signed [COORD_WIDTH-1:0] i_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_z,
    output logic signed [COORD_WIDTH-1:0]      o_value,
    output logic                               o_sat
);

    localparam int FRAC   = COEF_WIDTH - COEF_INT_BITS;
    localparam int PROD_W = COORD_WIDTH + COEF_WIDTH;
    localparam int SUM_W  = PROD_W + 2;
    localparam int RND_W  = SUM_W - FRAC;
    localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC - 1);
    localparam logic signed [COORD_WIDTH-1:0] MAXV = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] MINV = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic signed [COEF_WIDTH-1:0]  w_c0, w_c1, w_c2;
    logic signed [PROD_W-1:0]      r_p0, r_p1, r_p2;
    logic signed [COORD_WIDTH-1:0] r_shift;
    logic signed [SUM_W-1:0]       r_pa, r_pb;
    logic signed [SUM_W-1:0]       w_sum, w_sar;
    logic signed [RND_W-1:0]       w_rnd;
    logic                          w_fits;
    logic signed [COORD_WIDTH-1:0] n_value;
    logic                          n_sat;

    assign w_c0 = i_coefs[0*COEF_WIDTH +: COEF_WIDTH];
    assign w_c1 = i_coefs[1*COEF_WIDTH +: COEF_WIDTH];
    assign w_c2 = i_coefs[2*COEF_WIDTH +: COEF_WIDTH];

    // Stage 1: one multiplier per column.
    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_p0    <= w_c0 * i_x;
            r_p1    <= w_c1 * i_y;
            r_p2    <= w_c2 * i_z;
            r_shift <= i_shift;
        end
    end

    // Stage 2: pairwise sums; the translation is aligned to the product scale
    // and carries the rounding half.
    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_pa <= SUM_W'(r_p0) + SUM_W'(r_p1);
            r_pb <= SUM_W'(r_p2) + (SUM_W'(r_shift) <<< FRAC) + HALF;
        end
    end

    // Stage 3: final add, drop the fraction, clip to the coordinate range.
    always_comb begin
        w_sum  = r_pa + r_pb;
        w_sar  = w_sum >>> FRAC;
        w_rnd  = w_sar[RND_W-1:0];
        w_fits = (&w_rnd[RND_W-1:COORD_WIDTH-1]) || !(|w_rnd[RND_W-1:COORD_WIDTH-1]);
        n_sat  = !w_fits;
        if (w_fits) begin
            n_value = w_rnd[COORD_WIDTH-1:0];
        end else if (w_rnd[RND_W-1]) begin
            n_value = MINV;
        end else begin
            n_value = MAXV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            o_value <= n_value;
            o_sat   <= n_sat;
        end
    end

endmodule

`default_nettype wire

// File: rtl/apt_merge.sv
`default_nettype none

module apt_merge
    import apt_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic signed [COORD_WIDTH-1:0] i_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_z,
    input  wire logic [NUM_ROWS-1:0]           i_sat,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic signed [COORD_WIDTH-1:0]      o_out_x,
    output logic signed [COORD_WIDTH-1:0]      o_out_y,
    output logic signed [COORD_WIDTH-1:0]      o_out_z,
    output logic                               o_saturated
);

    logic r_valid;
    logic n_valid;
    logic w_load;

    // The output register takes a new word whenever it is empty or being drained.
    assign o_ready = !r_valid || i_out_ready;
    assign w_load  = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_out_x     <= i_x;
            o_out_y     <= i_y;
            o_out_z     <= i_z;
            o_saturated <= |i_sat;
        end
    end

    assign o_out_valid = r_valid;

endmodule

`default_nettype wire

// File: rtl/affine_point_transform_top.sv
`default_nettype none
// Channel   Direction  Handshake                     Payload
// config    in         i_cfg_we                      i_cfg_idx, i_cfg_data
// point in  in         i_in_valid / o_in_ready       i_in_x, i_in_y, i_in_z
// point out out        o_out_valid / i_out_ready     o_out_x, o_out_y, o_out_z, o_saturated
//
// One point is accepted per cycle while the output does not stall; its result passes
// through the multiply, pairwise add, final add with round and clip, and output register.
// Three row lanes run side by side; each feeds its value to the output register.
// Reset is synchronous and active low; it empties the pipeline and loads the
// identity matrix with zero translation.
// A stalled output backs up stage by stage; input is taken while any stage is free.

module affine_point_transform_top
    import apt_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int COEF_WIDTH  = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [2:0]                    i_cfg_idx,
    input  wire logic [((3*COEF_WIDTH > COORD_WIDTH) ? 3*COEF_WIDTH : COORD_WIDTH)-1:0]
                                               i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic signed [COORD_WIDTH-1:0] i_in_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_in_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_in_z,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic signed [COORD_WIDTH-1:0]      o_out_x,
    output logic signed [COORD_WIDTH-1:0]      o_out_y,
    output logic signed [COORD_WIDTH-1:0]      o_out_z,
    output logic                               o_saturated
);

    localparam int ROW_W = 3 * COEF_WIDTH;
    localparam logic [ROW_W-1:0] ONE = ROW_W'(1) << (COEF_WIDTH - COEF_INT_BITS);
    localparam logic signed [COORD_WIDTH-1:0] MAXV = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] MINV = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic [ROW_W-1:0]              r_row0, r_row1, r_row2;
    logic signed [COORD_WIDTH-1:0] r_shift_x, r_shift_y, r_shift_z;
    logic                          r_v1, r_v2, r_v3;
    logic                          n_v1, n_v2, n_v3;
    logic                          w_rdy1, w_rdy2, w_rdy3, w_rdy_o;
    t_stage_en                     w_en;
    logic signed [COORD_WIDTH-1:0] w_val_x, w_val_y, w_val_z;
    logic [NUM_ROWS-1:0]           w_sat;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row0    <= ONE;
            r_row1    <= ONE << COEF_WIDTH;
            r_row2    <= ONE << (2 * COEF_WIDTH);
            r_shift_x <= '0;
            r_shift_y <= '0;
            r_shift_z <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                REG_ROW0_LINEAR: r_row0    <= i_cfg_data[ROW_W-1:0];
                REG_ROW1_LINEAR: r_row1    <= i_cfg_data[ROW_W-1:0];
                REG_ROW2_LINEAR: r_row2    <= i_cfg_data[ROW_W-1:0];
                REG_SHIFT_X:     r_shift_x <= i_cfg_data[COORD_WIDTH-1:0];
                REG_SHIFT_Y:     r_shift_y <= i_cfg_data[COORD_WIDTH-1:0];
                REG_SHIFT_Z:     r_shift_z <= i_cfg_data[COORD_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // A stage can load when it is empty or its word moves on this cycle.
    assign w_rdy3     = !r_v3 || w_rdy_o;
    assign w_rdy2     = !r_v2 || w_rdy3;
    assign w_rdy1     = !r_v1 || w_rdy2;
    assign o_in_ready = w_rdy1;

    assign w_en.s1 = i_in_valid && w_rdy1;
    assign w_en.s2 = r_v1 && w_rdy2;
    assign w_en.s3 = r_v2 && w_rdy3;

    always_comb begin
        n_v1 = w_rdy1 ? i_in_valid : r_v1;
        n_v2 = w_rdy2 ? r_v1 : r_v2;
        n_v3 = w_rdy3 ? r_v2 : r_v3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_v3 <= n_v3;
        end
    end

    apt_lane #(
        .COORD_WIDTH(COORD_WIDTH),
        .COEF_WIDTH (COEF_WIDTH)
    ) u_lane_x (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_coefs(r_row0),
        .i_shift(r_shift_x),
        .i_x    (i_in_x),
        .i_y    (i_in_y),
        .i_z    (i_in_z),
        .o_value(w_val_x),
        .o_sat  (w_sat[0])
    );

    apt_lane #(
        .COORD_WIDTH(COORD_WIDTH),
        .COEF_WIDTH (COEF_WIDTH)
    ) u_lane_y (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_coefs(r_row1),
        .i_shift(r_shift_y),
        .i_x    (i_in_x),
        .i_y    (i_in_y),
        .i_z    (i_in_z),
        .o_value(w_val_y),
        .o_sat  (w_sat[1])
    );

    apt_lane #(
        .COORD_WIDTH(COORD_WIDTH),
        .COEF_WIDTH (COEF_WIDTH)
    ) u_lane_z (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_coefs(r_row2),
        .i_shift(r_shift_z),
        .i_x    (i_in_x),
        .i_y    (i_in_y),
        .i_z    (i_in_z),
        .o_value(w_val_z),
        .o_sat  (w_sat[2])
    );

    apt_merge #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_v3),
        .o_ready    (w_rdy_o),
        .i_x        (w_val_x),
        .i_y        (w_val_y),
        .i_z        (w_val_z),
        .i_sat      (w_sat),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_x    (o_out_x),
        .o_out_y    (o_out_y),
        .o_out_z    (o_out_z),
        .o_saturated(o_saturated)
    );

    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_v1)
        else $error("accepted word did not enter the first stage");

    a_stall_holds_s3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && o_out_valid && !i_out_ready) |=> r_v3)
        else $error("last lane stage lost a word while the output stalled");

    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_v3 && o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while every stage is full and stalled");

    a_sat_at_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |->
            (o_out_x == MAXV || o_out_x == MINV || o_out_y == MAXV ||
             o_out_y == MINV || o_out_z == MAXV || o_out_z == MINV))
        else $error("saturation flagged but no coordinate sits at a bound");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_v1 && !r_v2 && !r_v3 && !o_out_valid))
        else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

// File: bench/tb_affine_point_transform_top.sv
module tb_affine_point_transform_top;
    import apt_pkg::*;

    localparam int COORD_W     = 32;
    localparam int COEF_W      = 16;
    localparam int CFG_W       = 48;
    localparam int FRAC        = COEF_W - COEF_INT_BITS;
    localparam int PIPE_DEPTH  = 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MIX_PHASES  = 8;
    localparam int PHASE_WORDS = 167;

    // Indexes past the last register; writes there must change nothing.
    localparam logic [2:0] IDX_SPARE_A = 3'd6;
    localparam logic [2:0] IDX_SPARE_B = 3'd7;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
    localparam logic [COEF_W-1:0] COEF_ONE      = 16'h1000;
    localparam logic [COEF_W-1:0] COEF_HALF     = 16'h0800;
    localparam logic [COEF_W-1:0] COEF_NEG_HALF = 16'hF800;
    localparam logic [COEF_W-1:0] COEF_MAX      = 16'h7FFF;
    localparam logic [COEF_W-1:0] COEF_MIN      = 16'h8000;

    typedef enum {MIX_ANY, MIX_SMALL, MIX_EXTREME, MIX_DIAGONAL} t_matrix_mix;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      sat;
    } t_point_result;

    class point_scoreboard;
        logic [CFG_W-1:0]          lin [3];
        logic signed [COORD_W-1:0] shift [3];
        t_point_result             awaited [$];
        int                        errors;

        function new();
            lin[0]   = CFG_W'(COEF_ONE);
            lin[1]   = CFG_W'(COEF_ONE) << COEF_W;
            lin[2]   = CFG_W'(COEF_ONE) << (2 * COEF_W);
            shift[0] = '0;
            shift[1] = '0;
            shift[2] = '0;
            errors   = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_ROW0_LINEAR: lin[0] = data;
                REG_ROW1_LINEAR: lin[1] = data;
                REG_ROW2_LINEAR: lin[2] = data;
                REG_SHIFT_X:     shift[0] = data[COORD_W-1:0];
                REG_SHIFT_Y:     shift[1] = data[COORD_W-1:0];
                REG_SHIFT_Z:     shift[2] = data[COORD_W-1:0];
                default: ;
            endcase
        endfunction

        // Exact sum in 64 bits, round half up, then clip to the coordinate range.
        function logic signed [COORD_W-1:0] transform_row(int r,
                logic signed [COORD_W-1:0] px, logic signed [COORD_W-1:0] py,
                logic signed [COORD_W-1:0] pz, inout logic sat);
            longint acc;
            acc = longint'(shift[r]) <<< FRAC;
            acc += longint'($signed(lin[r][0 +: COEF_W])) * longint'(px);
            acc += longint'($signed(lin[r][COEF_W +: COEF_W])) * longint'(py);
            acc += longint'($signed(lin[r][2*COEF_W +: COEF_W])) * longint'(pz);
            acc += longint'(1) <<< (FRAC - 1);
            acc = acc >>> FRAC;
            if (acc > longint'(COORD_MAX)) begin
                sat = 1'b1;
                return COORD_MAX;
            end
            if (acc < longint'(COORD_MIN)) begin
                sat = 1'b1;
                return COORD_MIN;
            end
            return acc[COORD_W-1:0];
        endfunction

        function void note_point(logic signed [COORD_W-1:0] x,
                logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z);
            t_point_result e;
            logic          s;
            s     = 1'b0;
            e.x   = transform_row(0, x, y, z, s);
            e.y   = transform_row(1, x, y, z, s);
            e.z   = transform_row(2, x, y, z, s);
            e.sat = s;
            awaited.push_back(e);
        endfunction

        function void check_result(logic signed [COORD_W-1:0] x,
                logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z,
                logic sat);
            t_point_result e;
            if (awaited.size() == 0) begin
                $error("result word with no point waiting: x=%0d y=%0d z=%0d", x, y, z);
                errors++;
                return;
            end
            e = awaited.pop_front();
            if (x !== e.x) begin
                $error("out_x: expected %0d, got %0d", e.x, x);
                errors++;
            end
            if (y !== e.y) begin
                $error("out_y: expected %0d, got %0d", e.y, y);
                errors++;
            end
            if (z !== e.z) begin
                $error("out_z: expected %0d, got %0d", e.z, z);
                errors++;
            end
            if (sat !== e.sat) begin
                $error("saturated: expected %0d, got %0d", e.sat, sat);
                errors++;
            end
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [2:0]                i_cfg_idx;
    logic [CFG_W-1:0]          i_cfg_data;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic signed [COORD_W-1:0] i_in_x;
    logic signed [COORD_W-1:0] i_in_y;
    logic signed [COORD_W-1:0] i_in_z;
    logic                      o_out_valid;
    logic                      i_out_ready;
    logic signed [COORD_W-1:0] o_out_x;
    logic signed [COORD_W-1:0] o_out_y;
    logic signed [COORD_W-1:0] o_out_z;
    logic                      o_saturated;

    point_scoreboard sb = new();
    bit              full_rate = 1'b0;
    int unsigned     cycle_count = 0;

    affine_point_transform_top #(
        .COORD_WIDTH(COORD_W),
        .COEF_WIDTH (COEF_W)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_x     (i_in_x),
        .i_in_y     (i_in_y),
        .i_in_z     (i_in_z),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_x    (o_out_x),
        .o_out_y    (o_out_y),
        .o_out_z    (o_out_z),
        .o_saturated(o_saturated)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_out_x, o_out_y, o_out_z, o_saturated);
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [COORD_W-1:0] random_coord();
        logic [COORD_W-1:0] v;
        int                 k;
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 4))
                0:       return COORD_MAX;
                1:       return COORD_MIN;
                2:       return 0;
                3:       return 1;
                default: return -1;
            endcase
        end
        // Random magnitude so that both clipped and in-range sums are common.
        k = $urandom_range(1, COORD_W);
        v = $urandom;
        return $signed(v << (COORD_W - k)) >>> (COORD_W - k);
    endfunction

    function automatic logic [COEF_W-1:0] random_coef(int w);
        logic [COEF_W-1:0] v;
        int                k;
        k = $urandom_range(1, w);
        v = COEF_W'($urandom);
        return $signed(v << (COEF_W - k)) >>> (COEF_W - k);
    endfunction

    function automatic logic [CFG_W-1:0] pack_row(logic [COEF_W-1:0] c0,
            logic [COEF_W-1:0] c1, logic [COEF_W-1:0] c2);
        return {c2, c1, c0};
    endfunction

    initial begin
        int stall;
        stall = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (full_rate || stall == 0) begin
                i_out_ready <= 1'b1;
                if (!full_rate && $urandom_range(0, 2) == 0)
                    stall = pick_gap();
            end else begin
                i_out_ready <= 1'b0;
                stall--;
            end
        end
    end

    // Called just after a falling edge; returns just after the falling edge
    // that follows acceptance of the word.
    task automatic send_point(input logic signed [COORD_W-1:0] x,
            input logic signed [COORD_W-1:0] y, input logic signed [COORD_W-1:0] z);
        int gap;
        gap = full_rate ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_x     <= x;
        i_in_y     <= y;
        i_in_z     <= z;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        sb.note_point(x, y, z);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge i_clk);
        repeat (PIPE_DEPTH) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic put_reg(input logic [2:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    // Shift writes carry junk above bit 31, which the block must drop.
    task automatic load_matrix(input logic [CFG_W-1:0] r0, input logic [CFG_W-1:0] r1,
            input logic [CFG_W-1:0] r2, input logic signed [COORD_W-1:0] sx,
            input logic signed [COORD_W-1:0] sy, input logic signed [COORD_W-1:0] sz,
            input bit touch_spare);
        put_reg(REG_ROW0_LINEAR, r0);
        put_reg(REG_ROW1_LINEAR, r1);
        put_reg(REG_ROW2_LINEAR, r2);
        put_reg(REG_SHIFT_X, {16'($urandom), sx});
        put_reg(REG_SHIFT_Y, {16'($urandom), sy});
        put_reg(REG_SHIFT_Z, {16'($urandom), sz});
        if (touch_spare) begin
            put_reg(IDX_SPARE_A, {16'($urandom), 32'($urandom)});
            put_reg(IDX_SPARE_B, {16'($urandom), 32'($urandom)});
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_matrix(input t_matrix_mix mix);
        logic [CFG_W-1:0]          rows [3];
        logic signed [COORD_W-1:0] sh [3];
        logic [COEF_W-1:0]         c;
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                case (mix)
                    MIX_ANY:     c = COEF_W'($urandom);
                    MIX_SMALL:   c = random_coef(COEF_W - 3);
                    MIX_EXTREME: c = $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
                    default:     c = (r == k) ? random_coef(COEF_W) : '0;
                endcase
                rows[r][k*COEF_W +: COEF_W] = c;
            end
            if (mix == MIX_EXTREME)
                sh[r] = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
            else
                sh[r] = random_coord();
        end
        load_matrix(rows[0], rows[1], rows[2], sh[0], sh[1], sh[2],
                    $urandom_range(0, 2) == 0);
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in_x     = '0;
        i_in_y     = '0;
        i_in_z     = '0;
        // Hold reset low over the counted rising edges, then release it at a falling edge.
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // The reset matrix is the identity, so points pass through unchanged.
        send_point(0, 0, 0);
        send_point(COORD_MAX, COORD_MIN, 1);
        send_point(COORD_MIN, COORD_MAX, -1);
        send_point(32'sh0001_0000, -32'sh0001_0000, 32'sh7FFF_0000);
        drain();

        // Half-LSB products exercise round-half-up in both signs.
        load_matrix(pack_row(COEF_HALF, 0, 0), pack_row(COEF_NEG_HALF, 0, 0),
                    pack_row(0, 0, COEF_ONE), 0, 0, COORD_MAX, 1'b1);
        send_point(1, 0, 0);
        send_point(-1, 0, 1);
        send_point(3, 0, -1);
        send_point(-3, 0, 0);
        send_point(2, 0, COORD_MIN);
        drain();

        // Largest coefficients and shifts push rows into clipping at both bounds.
        load_matrix(pack_row(COEF_MAX, COEF_MAX, COEF_MAX),
                    pack_row(COEF_MIN, COEF_MIN, COEF_MIN),
                    pack_row(COEF_MAX, COEF_MIN, 0),
                    COORD_MAX, COORD_MIN, COORD_MIN, 1'b0);
        send_point(COORD_MAX, COORD_MAX, COORD_MAX);
        send_point(COORD_MIN, COORD_MIN, COORD_MIN);
        send_point(COORD_MAX, COORD_MIN, 0);
        send_point(0, 0, 0);
        send_point(1, 1, 1);
        send_point(-1, -1, -1);
        drain();

        for (int ph = 0; ph < MIX_PHASES; ph++) begin
            random_matrix(t_matrix_mix'(ph % 4));
            full_rate = (ph == 1 || ph == 6);
            for (int n = 0; n < PHASE_WORDS; n++)
                send_point(random_coord(), random_coord(), random_coord());
            drain();
        end
        full_rate = 1'b0;

        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: files.f
rtl/apt_pkg.sv
rtl/apt_lane.sv
rtl/apt_merge.sv
rtl/affine_point_transform_top.sv
bench/tb_affine_point_transform_top.sv
